[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker in wvm_chk.sv.
// Each macro takes a label, a clock, a reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequence must hold in the same cycle as the condition.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequence must hold in the cycle after the condition.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/wvm_pkg.sv]
// Shared constants for the windowed vector mean block.
// No dependencies.
`timescale 1ns / 1ps

package wvm_pkg;

  localparam int DEPTH_DEF    = 64;
  localparam int SAMPLE_W_DEF = 24;
  localparam int ACTION_W     = 2;
  localparam int LEN_W        = 7;
  localparam int MEAN_W       = 24;
  localparam int AXES         = 3;

  localparam logic [ACTION_W-1:0] ACT_STORE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MEAN  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

endpackage

[hdl/wvm_div.sv]
// Three-lane signed-by-unsigned divider, one quotient bit per cycle, shared control.
// Truncates toward zero. Depends on wvm_pkg.
`timescale 1ns / 1ps

module wvm_div #(
  parameter int DW = 31,
  parameter int VW = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [wvm_pkg::AXES-1:0][DW-1:0]    dividend,
  input  logic [VW-1:0]                       divisor,
  output logic                                done,
  output logic [wvm_pkg::AXES-1:0][DW-1:0]    quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic                                busy_r;
  logic                                done_r;
  logic [CNTW-1:0]                     cnt_r;
  logic [VW-1:0]                       dsr_r;
  logic [wvm_pkg::AXES-1:0]            neg_r;
  logic [wvm_pkg::AXES-1:0][VW-1:0]    rem_r;
  logic [wvm_pkg::AXES-1:0][DW-1:0]    quo_r;
  logic [wvm_pkg::AXES-1:0][VW-1:0]    rem_nxt;
  logic [wvm_pkg::AXES-1:0][DW-1:0]    quo_nxt;

  always_comb begin
    logic [VW:0] shifted;
    logic [VW:0] diff;
    for (int k = 0; k < wvm_pkg::AXES; k++) begin
      shifted    = {rem_r[k], quo_r[k][DW-1]};
      diff       = shifted - {1'b0, dsr_r};
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt[k] = diff[VW-1:0];
        quo_nxt[k] = {quo_r[k][DW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = shifted[VW-1:0];
        quo_nxt[k] = {quo_r[k][DW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitudes shift through quo_r, sign restored at the output
  always_ff @(posedge clk) begin
    if (start) begin
      dsr_r <= divisor;
      for (int k = 0; k < wvm_pkg::AXES; k++) begin
        neg_r[k] <= dividend[k][DW-1];
        rem_r[k] <= '0;
        quo_r[k] <= dividend[k][DW-1] ? (~dividend[k] + 1'b1) : dividend[k];
      end
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < wvm_pkg::AXES; k++) begin
      quotient[k] = neg_r[k] ? (~quo_r[k] + 1'b1) : quo_r[k];
    end
  end

  assign done = done_r;

endmodule

[hdl/windowed_vector_mean_ring.sv]
// Windowed three-axis mean over a ring of samples held in one synchronous memory.
// Store and clear complete without stalling and may follow back to back; no result.
// Mean with clamped length n: reads n samples from memory and sums them, then divides
// each sum, SAMPLE_WIDTH + 7 bits wide, by n; n = 0 skips both and gives zero means.
// A mean holds off new input until its result is registered; the result may wait there.
// Reset (synchronous, rst_n low) empties the ring; memory contents are not cleared.
`timescale 1ns / 1ps

module windowed_vector_mean_ring #(
  parameter int DEPTH        = wvm_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = wvm_pkg::SAMPLE_W_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [wvm_pkg::ACTION_W-1:0]       in_action,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_accel_x,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_accel_y,
  input  logic signed [SAMPLE_WIDTH-1:0]     in_accel_z,
  input  logic [wvm_pkg::LEN_W-1:0]          in_window_len,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [wvm_pkg::MEAN_W-1:0]  out_mean_x,
  output logic signed [wvm_pkg::MEAN_W-1:0]  out_mean_y,
  output logic signed [wvm_pkg::MEAN_W-1:0]  out_mean_z,
  output logic [wvm_pkg::LEN_W-1:0]          out_used_count
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int LW    = (CW > wvm_pkg::LEN_W) ? CW : wvm_pkg::LEN_W;
  localparam int SW    = SAMPLE_WIDTH;
  localparam int SUMW  = SW + wvm_pkg::LEN_W;
  localparam int EXTW  = (SUMW > wvm_pkg::MEAN_W) ? SUMW : wvm_pkg::MEAN_W;
  localparam int WORDW = wvm_pkg::AXES * SW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]                     wslot_r;
  logic [CW-1:0]                     fill_r;
  logic [AW-1:0]                     rd_addr_r;
  logic [wvm_pkg::LEN_W-1:0]         iss_r;
  logic [wvm_pkg::LEN_W-1:0]         n_r;
  logic                              rd_vld_r;
  logic [WORDW-1:0]                  rd_data_r;
  logic [WORDW-1:0]                  mem [DEPTH];
  logic signed [SUMW-1:0]            acc_r [wvm_pkg::AXES];

  logic                              in_acc;
  logic                              wr_en;
  logic                              rd_en;
  logic                              div_start;
  logic                              div_done;
  logic                              out_load;
  logic [LW-1:0]                     fill_ext;
  logic [LW-1:0]                     len_ext;
  logic [wvm_pkg::LEN_W-1:0]         n_sel;
  logic [AW-1:0]                     newest;
  logic [wvm_pkg::AXES-1:0][SUMW-1:0] div_dvd;
  logic [wvm_pkg::AXES-1:0][SUMW-1:0] div_quo;
  logic signed [EXTW-1:0]            q_ext [wvm_pkg::AXES];

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (in_action == wvm_pkg::ACT_STORE);
  assign rd_en    = (state_r == S_SUM) && (iss_r != '0);

  assign fill_ext = LW'(fill_r);
  assign len_ext  = LW'(in_window_len);
  assign n_sel    = (len_ext > fill_ext) ? fill_ext[wvm_pkg::LEN_W-1:0] : in_window_len;
  assign newest   = (wslot_r == '0) ? AW'(DEPTH - 1) : (wslot_r - 1'b1);

  assign div_start = (state_r == S_SUM) && (iss_r == '0) && !rd_vld_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_action == wvm_pkg::ACT_MEAN)) begin
          state_nxt = (n_sel == '0) ? S_DONE : S_SUM;
        end
      end
      S_SUM: begin
        if (div_start) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wslot_r  <= '0;
      fill_r   <= '0;
      iss_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (wr_en) begin
        wslot_r <= (wslot_r == AW'(DEPTH - 1)) ? '0 : (wslot_r + 1'b1);
        if (fill_r != CW'(DEPTH)) fill_r <= fill_r + 1'b1;
      end
      if (in_acc && (in_action == wvm_pkg::ACT_CLEAR)) begin
        wslot_r <= '0;
        fill_r  <= '0;
      end
      if (in_acc && (in_action == wvm_pkg::ACT_MEAN)) begin
        iss_r <= n_sel;
      end else if (rd_en) begin
        iss_r <= iss_r - 1'b1;
      end
    end
  end

  // Sample memory: one write port for stores, one registered read port for the walk
  always_ff @(posedge clk) begin
    if (wr_en) mem[wslot_r] <= {in_accel_z, in_accel_y, in_accel_x};
    if (rd_en) rd_data_r <= mem[rd_addr_r];
  end

  // Walk backward from the newest entry, summing each word in the cycle after its read
  always_ff @(posedge clk) begin
    if (in_acc && (in_action == wvm_pkg::ACT_MEAN)) begin
      n_r       <= n_sel;
      rd_addr_r <= newest;
      for (int k = 0; k < wvm_pkg::AXES; k++) acc_r[k] <= '0;
    end else begin
      if (rd_en) begin
        rd_addr_r <= (rd_addr_r == '0) ? AW'(DEPTH - 1) : (rd_addr_r - 1'b1);
      end
      if (rd_vld_r) begin
        for (int k = 0; k < wvm_pkg::AXES; k++) begin
          acc_r[k] <= acc_r[k] + SUMW'($signed(rd_data_r[k*SW +: SW]));
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < wvm_pkg::AXES; k++) begin
      div_dvd[k] = acc_r[k];
      q_ext[k]   = EXTW'($signed(div_quo[k]));
    end
  end

  wvm_div #(
    .DW (SUMW),
    .VW (wvm_pkg::LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (n_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Output register; holds the result while the far side stalls
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_used_count <= n_r;
      if (n_r == '0) begin
        out_mean_x <= '0;
        out_mean_y <= '0;
        out_mean_z <= '0;
      end else begin
        out_mean_x <= q_ext[0][wvm_pkg::MEAN_W-1:0];
        out_mean_y <= q_ext[1][wvm_pkg::MEAN_W-1:0];
        out_mean_z <= q_ext[2][wvm_pkg::MEAN_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/wvm_chk.sv]
// Port-level checker for windowed_vector_mean_ring, with its bind statement.
// Depends on wvm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wvm_chk #(
  parameter int DEPTH = wvm_pkg::DEPTH_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [wvm_pkg::ACTION_W-1:0]       in_action,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [wvm_pkg::MEAN_W-1:0]  out_mean_x,
  input logic signed [wvm_pkg::MEAN_W-1:0]  out_mean_y,
  input logic signed [wvm_pkg::MEAN_W-1:0]  out_mean_z,
  input logic [wvm_pkg::LEN_W-1:0]          out_used_count
);

  logic mean_acc;
  logic out_wait;

  assign mean_acc = in_valid && !in_stall && (in_action == wvm_pkg::ACT_MEAN);
  assign out_wait = out_valid && out_stall;

  // an accepted mean transaction raises in_stall, holding off further input
  `ASSERT_NEXT(a_mean_busy, clk, rst_n, mean_acc, in_stall)

  // empty window gives zero means
  `ASSERT_SAME(a_empty_zero, clk, rst_n, out_valid && (out_used_count == '0),
    (out_mean_x == '0) && (out_mean_y == '0) && (out_mean_z == '0))

  // window never exceeds the ring depth
  `ASSERT_SAME(a_count_range, clk, rst_n, out_valid,
    32'(out_used_count) <= 32'(DEPTH))

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid)

  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_wait,
    $stable(out_mean_x) && $stable(out_mean_y) && $stable(out_mean_z) &&
    $stable(out_used_count))

endmodule

bind windowed_vector_mean_ring wvm_chk #(
  .DEPTH (DEPTH)
) u_wvm_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_action      (in_action),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_mean_x     (out_mean_x),
  .out_mean_y     (out_mean_y),
  .out_mean_z     (out_mean_z),
  .out_used_count (out_used_count)
);
